// ===== sv/psde_pkg.sv =====
// Shared types, constants and helper functions of the PNG stored-deflate encoder.
package psde_pkg;

  localparam int DIM_W     = 14;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] DIM_MIN = 14'd1;
  localparam logic [DIM_W-1:0] DIM_MAX = 14'd8192;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // One accepted pixel byte, tagged by the front with its place in the image.
  typedef struct packed {
    logic [7:0]       pix;
    logic             first;
    logic             row_start;
    logic             last;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } item_t;

  // One byte of the PNG stream with its markers.
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
  } out_t;

  typedef enum logic [2:0] {
    PH_NEW,
    PH_HDR,
    PH_FILT,
    PH_PIX,
    PH_TRL
  } ph_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_MUL,
    C_LOAD,
    C_DIV,
    C_SUM,
    C_DONE
  } cst_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_MIN) begin
      r = DIM_MIN;
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end
    return r;
  endfunction

endpackage

// ===== sv/psde_queue.sv =====
// Small first-in first-out queue of packed items with a combinational head.
module psde_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] head,
  output logic         q_full,
  output logic         q_empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign q_full  = (cnt_r == (AW+1)'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign head    = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

endmodule

// ===== sv/psde_front.sv =====
// Front part: configuration registers, image position tracking and item tagging.
module psde_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [psde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psde_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           push,
  input  logic [7:0]                     in_pixel_byte,
  output logic                           full,
  output logic                           q_wr,
  output psde_pkg::item_t                q_data,
  input  logic                           q_full
);
  import psde_pkg::*;

  logic [DIM_W-1:0] cfg_w_r, cfg_h_r, lat_w_r, lat_h_r;
  logic             started_r;
  logic [14:0]      col_r;
  logic [13:0]      row_r;
  logic [DIM_W-1:0] w_use, h_use;
  logic [15:0]      w3, col_inc;
  logic [13:0]      row_inc;
  logic             row_end, img_end, acc;

  assign full = q_full;
  assign acc  = push && !q_full;

  always_comb begin
    w_use   = started_r ? lat_w_r : clamp_dim(cfg_w_r);
    h_use   = started_r ? lat_h_r : clamp_dim(cfg_h_r);
    w3      = {1'b0, w_use, 1'b0} + {2'b00, w_use};
    col_inc = {1'b0, col_r} + 16'd1;
    row_inc = row_r + 14'd1;
    row_end = (col_inc == w3);
    img_end = row_end && (row_inc == h_use);
  end

  always_comb begin
    q_wr             = acc;
    q_data.pix       = in_pixel_byte;
    q_data.first     = !started_r;
    q_data.row_start = (col_r == '0);
    q_data.last      = img_end;
    q_data.w         = w_use;
    q_data.h         = h_use;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= DIM_MIN;
      cfg_h_r   <= DIM_MIN;
      started_r <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
      lat_w_r   <= DIM_MIN;
      lat_h_r   <= DIM_MIN;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) begin
          cfg_w_r <= cfg_data;
        end else if (cfg_index == CFG_HEIGHT) begin
          cfg_h_r <= cfg_data;
        end
      end
      if (acc) begin
        if (!started_r) begin
          started_r <= 1'b1;
          lat_w_r   <= w_use;
          lat_h_r   <= h_use;
        end
        if (row_end) begin
          col_r <= '0;
          if (img_end) begin
            row_r     <= '0;
            started_r <= 1'b0;
          end else begin
            row_r <= row_inc;
          end
        end else begin
          col_r <= col_inc[14:0];
        end
      end
    end
  end

endmodule

// ===== sv/psde_back.sv =====
// Back part: byte sequencer for headers, stored blocks, checksums and trailer.
module psde_back #(
  parameter int STORED_BLOCK_MAX = 65535
) (
  input  logic            clk,
  input  logic            rst_n,
  input  psde_pkg::item_t q_head,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            oq_wr,
  output psde_pkg::out_t  oq_data,
  input  logic            oq_full
);
  import psde_pkg::*;

  localparam logic [15:0] BLK_MAX  = 16'(STORED_BLOCK_MAX);
  localparam logic [5:0]  HDR_CRC0 = 6'd12;
  localparam logic [5:0]  HDR_CRC1 = 6'd28;
  localparam logic [5:0]  HDR_LEN  = 6'd33;
  localparam logic [5:0]  HDR_TYP  = 6'd37;
  localparam logic [5:0]  HDR_LAST = 6'd42;
  localparam logic [5:0]  BLK_LAST = 6'd4;
  localparam logic [5:0]  TRL_TYP  = 6'd12;
  localparam logic [5:0]  TRL_LAST = 6'd19;
  // The block count is a 28-bit dividend times a rounded-up reciprocal of the block
  // size, shifted down; the extra shift by the divisor's bit count keeps it exact.
  localparam int          DIV_SH   = 28 + $clog2(STORED_BLOCK_MAX);
  localparam logic [29:0] RECIP    = 30'(((64'd1 << DIV_SH) + 64'(STORED_BLOCK_MAX)
                                          - 64'd1) / 64'(STORED_BLOCK_MAX));

  ph_t              phase_r, phase_nxt, eff;
  logic [5:0]       idx_r, idx_nxt;
  logic [31:0]      crc_r;
  logic [15:0]      adl_lo_r, adl_hi_r;
  logic [27:0]      raw_off_r;
  logic [15:0]      bleft_r;
  logic [DIM_W-1:0] lat_w_r, lat_h_r;
  cst_t             cst_r, cst_nxt;
  logic [27:0]      raw_total_r, quo_r;
  logic [31:0]      idat_r;
  logic             calc_done;

  logic        in_blk, fire, crc_en, crc_rst, raw_emit, hdr_start;
  logic [7:0]  byte_v;
  logic [27:0] remain;
  logic        blk_fin;
  logic [15:0] blk_n;
  logic [16:0] lo_sum, lo_mod, hi_sum, hi_mod;
  logic [15:0] w3p1;
  logic [29:0] prod;
  logic [57:0] rmul;

  assign calc_done = (cst_r == C_DONE);

  // Which part of the stream the head item is in.
  always_comb begin
    if (phase_r == PH_NEW) begin
      if (q_head.first) begin
        eff = PH_HDR;
      end else if (q_head.row_start) begin
        eff = PH_FILT;
      end else begin
        eff = PH_PIX;
      end
    end else begin
      eff = phase_r;
    end
    in_blk  = ((eff == PH_FILT) || (eff == PH_PIX)) && (bleft_r == '0);
    remain  = raw_total_r - raw_off_r;
    blk_fin = (remain <= {12'd0, BLK_MAX});
    blk_n   = blk_fin ? remain[15:0] : BLK_MAX;
    fire    = !q_empty && !oq_full
              && !((eff == PH_HDR) && (idx_r >= HDR_LEN) && !calc_done)
              && !(in_blk && !calc_done);
  end

  // Output byte selection.
  always_comb begin
    byte_v         = 8'h00;
    crc_en         = 1'b0;
    crc_rst        = 1'b0;
    raw_emit       = 1'b0;
    oq_data        = '0;
    q_pop          = 1'b0;
    hdr_start      = 1'b0;
    unique case (eff)
      PH_HDR: begin
        hdr_start = (idx_r == '0);
        crc_en    = ((idx_r >= HDR_CRC0) && (idx_r <= HDR_CRC1)) || (idx_r >= HDR_TYP);
        crc_rst   = (idx_r == HDR_CRC0) || (idx_r == HDR_TYP);
        unique case (idx_r)
          6'd0:    byte_v = 8'h89;
          6'd1:    byte_v = 8'h50;
          6'd2:    byte_v = 8'h4E;
          6'd3:    byte_v = 8'h47;
          6'd4:    byte_v = 8'h0D;
          6'd5:    byte_v = 8'h0A;
          6'd6:    byte_v = 8'h1A;
          6'd7:    byte_v = 8'h0A;
          6'd11:   byte_v = 8'h0D;
          6'd12:   byte_v = 8'h49;
          6'd13:   byte_v = 8'h48;
          6'd14:   byte_v = 8'h44;
          6'd15:   byte_v = 8'h52;
          6'd18:   byte_v = {2'b00, lat_w_r[13:8]};
          6'd19:   byte_v = lat_w_r[7:0];
          6'd22:   byte_v = {2'b00, lat_h_r[13:8]};
          6'd23:   byte_v = lat_h_r[7:0];
          6'd24:   byte_v = 8'h08;
          6'd25:   byte_v = 8'h02;
          6'd29:   byte_v = ~crc_r[31:24];
          6'd30:   byte_v = ~crc_r[23:16];
          6'd31:   byte_v = ~crc_r[15:8];
          6'd32:   byte_v = ~crc_r[7:0];
          6'd33:   byte_v = idat_r[31:24];
          6'd34:   byte_v = idat_r[23:16];
          6'd35:   byte_v = idat_r[15:8];
          6'd36:   byte_v = idat_r[7:0];
          6'd37:   byte_v = 8'h49;
          6'd38:   byte_v = 8'h44;
          6'd39:   byte_v = 8'h41;
          6'd40:   byte_v = 8'h54;
          6'd41:   byte_v = 8'h78;
          6'd42:   byte_v = 8'h01;
          default: byte_v = 8'h00;
        endcase
      end
      PH_FILT, PH_PIX: begin
        crc_en = 1'b1;
        if (in_blk) begin
          unique case (idx_r)
            6'd0:    byte_v = {7'd0, blk_fin};
            6'd1:    byte_v = blk_n[7:0];
            6'd2:    byte_v = blk_n[15:8];
            6'd3:    byte_v = ~blk_n[7:0];
            6'd4:    byte_v = ~blk_n[15:8];
            default: byte_v = 8'h00;
          endcase
        end else begin
          raw_emit        = 1'b1;
          byte_v          = (eff == PH_PIX) ? q_head.pix : 8'h00;
          oq_data.run_last = (eff == PH_PIX) && !q_head.last;
          q_pop           = fire && (eff == PH_PIX) && !q_head.last;
        end
      end
      PH_TRL: begin
        crc_en  = (idx_r <= 6'd3) || ((idx_r >= TRL_TYP) && (idx_r <= 6'd15));
        crc_rst = (idx_r == TRL_TYP);
        unique case (idx_r)
          6'd0:    byte_v = adl_hi_r[15:8];
          6'd1:    byte_v = adl_hi_r[7:0];
          6'd2:    byte_v = adl_lo_r[15:8];
          6'd3:    byte_v = adl_lo_r[7:0];
          6'd4:    byte_v = ~crc_r[31:24];
          6'd5:    byte_v = ~crc_r[23:16];
          6'd6:    byte_v = ~crc_r[15:8];
          6'd7:    byte_v = ~crc_r[7:0];
          6'd12:   byte_v = 8'h49;
          6'd13:   byte_v = 8'h45;
          6'd14:   byte_v = 8'h4E;
          6'd15:   byte_v = 8'h44;
          6'd16:   byte_v = ~crc_r[31:24];
          6'd17:   byte_v = ~crc_r[23:16];
          6'd18:   byte_v = ~crc_r[15:8];
          6'd19:   byte_v = ~crc_r[7:0];
          default: byte_v = 8'h00;
        endcase
        oq_data.run_last   = (idx_r == TRL_LAST);
        oq_data.stream_end = (idx_r == TRL_LAST);
        q_pop              = fire && (idx_r == TRL_LAST);
      end
      default: begin
        byte_v = 8'h00;
      end
    endcase
    oq_data.data = byte_v;
    oq_wr        = fire;
  end

  // Sequencer next state.
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    if (fire) begin
      unique case (eff)
        PH_HDR: begin
          if (idx_r == HDR_LAST) begin
            phase_nxt = PH_FILT;
            idx_nxt   = '0;
          end else begin
            phase_nxt = PH_HDR;
            idx_nxt   = idx_r + 6'd1;
          end
        end
        PH_FILT, PH_PIX: begin
          phase_nxt = eff;
          if (in_blk) begin
            idx_nxt = (idx_r == BLK_LAST) ? '0 : idx_r + 6'd1;
          end else if (eff == PH_FILT) begin
            phase_nxt = PH_PIX;
          end else begin
            phase_nxt = q_head.last ? PH_TRL : PH_NEW;
            idx_nxt   = '0;
          end
        end
        PH_TRL: begin
          if (idx_r == TRL_LAST) begin
            phase_nxt = PH_NEW;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 6'd1;
          end
        end
        default: begin
          phase_nxt = PH_NEW;
        end
      endcase
    end
  end

  always_comb begin
    lo_sum = {1'b0, adl_lo_r} + {9'd0, byte_v};
    lo_mod = (lo_sum >= ADLER_MOD) ? lo_sum - ADLER_MOD : lo_sum;
    hi_sum = {1'b0, adl_hi_r} + lo_mod;
    hi_mod = (hi_sum >= ADLER_MOD) ? hi_sum - ADLER_MOD : hi_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_NEW;
      idx_r     <= '0;
      crc_r     <= '1;
      adl_lo_r  <= 16'd1;
      adl_hi_r  <= '0;
      raw_off_r <= '0;
      bleft_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      if (fire) begin
        if (crc_en) begin
          crc_r <= crc_byte(crc_rst ? 32'hFFFFFFFF : crc_r, byte_v);
        end
        if (hdr_start) begin
          adl_lo_r  <= 16'd1;
          adl_hi_r  <= '0;
          raw_off_r <= '0;
          bleft_r   <= '0;
        end else if (in_blk && (idx_r == BLK_LAST)) begin
          bleft_r <= blk_n;
        end else if (raw_emit) begin
          bleft_r   <= bleft_r - 16'd1;
          raw_off_r <= raw_off_r + 28'd1;
          adl_lo_r  <= lo_mod[15:0];
          adl_hi_r  <= hi_mod[15:0];
        end
      end
    end
  end

  // Length unit: raw size, block count by reciprocal multiplication, IDAT length.
  always_comb begin
    cst_nxt = cst_r;
    if (fire && hdr_start) begin
      cst_nxt = C_MUL;
    end else begin
      unique case (cst_r)
        C_IDLE:  cst_nxt = C_IDLE;
        C_MUL:   cst_nxt = C_LOAD;
        C_LOAD:  cst_nxt = C_DIV;
        C_DIV:   cst_nxt = C_SUM;
        C_SUM:   cst_nxt = C_DONE;
        C_DONE:  cst_nxt = C_DONE;
        default: cst_nxt = C_IDLE;
      endcase
    end
  end

  always_comb begin
    w3p1 = {1'b0, lat_w_r, 1'b0} + {2'b00, lat_w_r} + 16'd1;
    prod = lat_h_r * w3p1;
    rmul = 58'(quo_r) * 58'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cst_r <= C_IDLE;
    end else begin
      cst_r <= cst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hdr_start) begin
      lat_w_r <= q_head.w;
      lat_h_r <= q_head.h;
    end
    unique case (cst_r)
      C_MUL: begin
        raw_total_r <= prod[27:0];
      end
      C_LOAD: begin
        quo_r <= raw_total_r + 28'(BLK_MAX) - 28'd1;
      end
      C_DIV: begin
        quo_r <= 28'(rmul >> DIV_SH);
      end
      C_SUM: begin
        idat_r <= {4'd0, raw_total_r} + {2'd0, quo_r, 2'b00} + {4'd0, quo_r} + 32'd6;
      end
      default: begin
      end
    endcase
  end

  a_len_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (eff == PH_HDR) && (idx_r >= HDR_LEN)) |-> calc_done)
    else $error("IDAT length sent before it was computed");

  a_raw_budget: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && raw_emit) |-> (bleft_r != '0))
    else $error("raw byte sent outside a stored block");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!q_empty && oq_wr))
    else $error("item retired without a byte emitted");

  a_trl_end: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (eff == PH_TRL) && (idx_r == TRL_LAST)) |=> (phase_r == PH_NEW))
    else $error("sequencer did not return to idle after the trailer");

endmodule

// ===== sv/png_stored_deflate_encoder.sv =====
// Top level of the streaming PNG encoder for 8-bit RGB images with stored deflate blocks.
//
// Feed the colour bytes of an image (R, G, B per pixel, rows top to bottom) through the
// push/full queue port; the complete PNG file comes out one byte per cycle on the
// empty/pop side while the input queue holds an item and the output queue has room.
// The first byte of an image brings out the signature, the IHDR chunk, the IDAT length
// and type and the zlib header (43 bytes); each row adds a zero filter byte and each
// stored block a five-byte header; the last pixel byte brings out the Adler-32, the
// IDAT CRC and the IEND chunk (20 bytes), and out_stream_end marks the final byte.
// Width and height are sampled and clamped to 1..8192 when an image starts, so a
// configuration write takes effect with the next image. Throughput is set by the
// output byte sequencer, which emits these bytes in turn: pixel bytes, filter bytes,
// block headers and the start and end sequences. The IDAT length comes from a multiply
// and a multiplication by the reciprocal of the block size, worked out in the multiply,
// load, divide and sum states after the first header byte; the length bytes wait for it.
// A four-entry input queue separates the tagging front from the sequencer, and a
// two-entry output queue lets the sequencer keep running while a byte waits to be taken.
module png_stored_deflate_encoder #(
  parameter int STORED_BLOCK_MAX = 65535
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [psde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psde_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           push,
  input  logic [7:0]                     in_pixel_byte,
  output logic                           full,
  input  logic                           pop,
  output logic                           empty,
  output logic [7:0]                     out_byte,
  output logic                           out_run_last,
  output logic                           out_stream_end
);
  import psde_pkg::*;

  logic  iq_wr, iq_rd, iq_full, iq_empty;
  item_t iq_wdata, iq_head;
  logic  oq_wr, oq_full;
  out_t  oq_wdata, oq_head;

  psde_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .in_pixel_byte (in_pixel_byte),
    .full          (full),
    .q_wr          (iq_wr),
    .q_data        (iq_wdata),
    .q_full        (iq_full)
  );

  // Tagged items waiting for the sequencer.
  psde_queue #(
    .W     ($bits(item_t)),
    .DEPTH (4)
  ) u_in_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (iq_wr),
    .wr_data (iq_wdata),
    .rd_en   (iq_rd),
    .head    (iq_head),
    .q_full  (iq_full),
    .q_empty (iq_empty)
  );

  psde_back #(
    .STORED_BLOCK_MAX (STORED_BLOCK_MAX)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (iq_head),
    .q_empty (iq_empty),
    .q_pop   (iq_rd),
    .oq_wr   (oq_wr),
    .oq_data (oq_wdata),
    .oq_full (oq_full)
  );

  // Output skid queue; its head is the oldest byte not yet taken.
  psde_queue #(
    .W     ($bits(out_t)),
    .DEPTH (2)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (oq_wr),
    .wr_data (oq_wdata),
    .rd_en   (pop),
    .head    (oq_head),
    .q_full  (oq_full),
    .q_empty (empty)
  );

  assign out_byte       = oq_head.data;
  assign out_run_last   = oq_head.run_last;
  assign out_stream_end = oq_head.stream_end;

endmodule
